>>> rtl/lipa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipa_pkg
// Shared types and constants of the lifo identifier pool allocator.
// ----------------------------------------------------------------------------
package lipa_pkg;

   // fixed field widths
   localparam int FUNC_W       = 2;
   localparam int FIELD_ID_W   = 16;
   localparam int STATUS_W     = 2;
   localparam int FREE_COUNT_W = 9;
   localparam int SPAN_W       = FIELD_ID_W + 1;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // parameter defaults
   localparam int DEPTH_DEFAULT    = 256;
   localparam int ID_WIDTH_DEFAULT = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_INIT  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_TRUNC = 2'd3
   } status_type;

   // register select, taken from address bit 2
   typedef enum logic {
      REG_ID_MIN = 1'b0,
      REG_ID_MAX = 1'b1
   } reg_sel_type;

   // shift command broadcast to every cell of the stack chain
   typedef struct packed {
      logic push;
      logic pop;
   } shift_ctl_type;

endpackage

>>> rtl/lipa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipa request / response channels
// Valid-ready channels carrying one operation and one result per transfer.
// ----------------------------------------------------------------------------
interface lipa_req_if;
   logic                               valid;
   logic                               ready;
   logic [lipa_pkg::FUNC_W-1:0]        func;
   logic [lipa_pkg::FIELD_ID_W-1:0]    id_value;

   modport source (output valid, output func, output id_value, input ready);
   modport sink   (input valid, input func, input id_value, output ready);
endinterface

interface lipa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lipa_pkg::FIELD_ID_W-1:0]    id_out;
   logic [lipa_pkg::STATUS_W-1:0]      status;
   logic [lipa_pkg::FREE_COUNT_W-1:0]  free_count;

   modport source (output valid, output id_out, output status, output free_count,
                   input ready);
   modport sink   (input valid, input id_out, input status, input free_count,
                   output ready);
endinterface

>>> rtl/lipa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipa_cell
// One stack entry: takes the entry above on push, the entry below on pop.
// ----------------------------------------------------------------------------
module lipa_cell #(
   parameter int ID_WIDTH = lipa_pkg::ID_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  lipa_pkg::shift_ctl_type ctl,
   input  logic [ID_WIDTH-1:0]     above_data,
   input  logic [ID_WIDTH-1:0]     below_data,
   output logic [ID_WIDTH-1:0]     data
);

   logic [ID_WIDTH-1:0] data_ff;
   logic [ID_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.push) begin
         data_in = above_data;
      end else if (ctl.pop) begin
         data_in = below_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/lipa_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipa_stack
// Shift-register stack: a row of cells, cell zero holds the top of stack.
// ----------------------------------------------------------------------------
module lipa_stack #(
   parameter int DEPTH    = lipa_pkg::DEPTH_DEFAULT,
   parameter int ID_WIDTH = lipa_pkg::ID_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  lipa_pkg::shift_ctl_type ctl,
   input  logic [ID_WIDTH-1:0]     push_data,
   output logic [ID_WIDTH-1:0]     top_data
);

   logic [ID_WIDTH-1:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ID_WIDTH-1:0] above;
      logic [ID_WIDTH-1:0] below;

      if (i == 0) begin : g_top
         assign above = push_data;
      end else begin : g_mid
         assign above = cell_data[i-1];
      end

      // bottom cell pulls in don't-care data, never read before a push
      if (i == DEPTH - 1) begin : g_bot
         assign below = '0;
      end else begin : g_up
         assign below = cell_data[i+1];
      end

      lipa_cell #(
         .ID_WIDTH (ID_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .above_data (above),
         .below_data (below),
         .data       (cell_data[i])
      );
   end

   assign top_data = cell_data[0];

endmodule

>>> rtl/lifo_id_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_id_pool_allocator
// Identifier pool kept as a last-in-first-out free list in a chain of cells.
// ----------------------------------------------------------------------------
// Allocate, free and the unused operation code are taken one item per cycle
// while the result register can take a new result, and each result appears
// in the output register on the next. Init empties the pool and pushes
// id_min upward, one identifier per cycle into the cell chain, keep in all
// (keep = number of identifiers kept, at most DEPTH), and its result appears
// after the last push; an empty range pushes nothing. No item is taken
// meanwhile. The rate is set by the cell chain, which moves by one entry per
// cycle. Stack contents need no clearing after reset; the block is ready at
// once. Configuration registers id_min and id_max sit at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module lifo_id_pool_allocator #(
   parameter int DEPTH    = lipa_pkg::DEPTH_DEFAULT,
   parameter int ID_WIDTH = lipa_pkg::ID_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   lipa_req_if.sink                          req_chan,
   lipa_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lipa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lipa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lipa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int FW     = lipa_pkg::FIELD_ID_W;
   localparam int SW     = lipa_pkg::SPAN_W;
   localparam int FC_W   = lipa_pkg::FREE_COUNT_W;
   localparam int DATA_W = lipa_pkg::CSR_DATA_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FILL = 2'b10
   } state_type;

   // configuration
   logic [FW-1:0] id_min_ff, id_min_in;
   logic [FW-1:0] id_max_ff, id_max_in;
   logic          csr_write;
   lipa_pkg::reg_sel_type csr_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel    = lipa_pkg::reg_sel_type'(csr_paddr[2]);

   always_comb begin
      id_min_in = id_min_ff;
      id_max_in = id_max_ff;
      if (csr_write) begin
         case (csr_sel)
            lipa_pkg::REG_ID_MIN: id_min_in = csr_pwdata[FW-1:0];
            lipa_pkg::REG_ID_MAX: id_max_in = csr_pwdata[FW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         lipa_pkg::REG_ID_MIN: csr_prdata = DATA_W'(id_min_ff);
         lipa_pkg::REG_ID_MAX: csr_prdata = DATA_W'(id_max_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // control state
   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           remain_ff, remain_in;
   logic [ID_WIDTH-1:0]     fill_id_ff, fill_id_in;
   logic                    trunc_ff, trunc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]           rsp_id_ff, rsp_id_in;
   lipa_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [FC_W-1:0]         rsp_count_ff, rsp_count_in;

   lipa_pkg::shift_ctl_type ctl;
   logic [ID_WIDTH-1:0]     push_data;
   logic [ID_WIDTH-1:0]     top_data;

   logic                    accept;
   logic                    rsp_free;
   logic [SW-1:0]           span;
   logic                    span_over;
   logic [CW-1:0]           keep;

   assign rsp_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) & rsp_free;
   assign accept         = req_chan.valid & req_chan.ready;

   // init range, valid only when id_max is not below id_min
   assign span      = SW'(id_max_ff) - SW'(id_min_ff) + SW'(1);
   assign span_over = span > SW'(DEPTH);
   assign keep      = span_over ? CW'(DEPTH) : CW'(span);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      fill_id_in    = fill_id_ff;
      trunc_in      = trunc_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ctl           = '0;
      push_data     = fill_id_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_status_in = lipa_pkg::STATUS_OK;
               case (lipa_pkg::func_type'(req_chan.func))
                  lipa_pkg::FUNC_ALLOC: begin
                     if (count_ff == '0) begin
                        rsp_status_in = lipa_pkg::STATUS_EMPTY;
                     end else begin
                        ctl.pop   = 1'b1;
                        count_in  = count_ff - CW'(1);
                        rsp_id_in = FW'(top_data);
                     end
                  end
                  lipa_pkg::FUNC_FREE: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = lipa_pkg::STATUS_FULL;
                     end else begin
                        ctl.push  = 1'b1;
                        push_data = ID_WIDTH'(req_chan.id_value);
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  lipa_pkg::FUNC_INIT: begin
                     count_in = '0;
                     if (id_max_ff >= id_min_ff) begin
                        // result comes when the last identifier is pushed
                        rsp_valid_in = 1'b0;
                        state_in     = ST_FILL;
                        remain_in    = keep;
                        fill_id_in   = ID_WIDTH'(id_min_ff);
                        trunc_in     = span_over;
                     end
                  end
                  default: ;
               endcase
               rsp_count_in = FC_W'(count_in);
            end
         end
         ST_FILL: begin
            ctl.push   = 1'b1;
            push_data  = fill_id_ff;
            count_in   = count_ff + CW'(1);
            fill_id_in = fill_id_ff + ID_WIDTH'(1);
            remain_in  = remain_ff - CW'(1);
            if (remain_ff == CW'(1)) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_status_in = trunc_ff ? lipa_pkg::STATUS_TRUNC : lipa_pkg::STATUS_OK;
               rsp_count_in  = FC_W'(count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         id_min_ff    <= '0;
         id_max_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
         id_min_ff    <= id_min_in;
         id_max_ff    <= id_max_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_id_ff    <= fill_id_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   lipa_stack #(
      .DEPTH    (DEPTH),
      .ID_WIDTH (ID_WIDTH)
   ) u_stack (
      .clock     (clock),
      .ctl       (ctl),
      .push_data (push_data),
      .top_data  (top_data)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.id_out     = rsp_id_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.free_count = rsp_count_ff;

endmodule

>>> rtl/lipa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipa_checker
// Port-level assertions for the lifo identifier pool allocator.
// ----------------------------------------------------------------------------
module lipa_checker #(
   parameter int DEPTH = lipa_pkg::DEPTH_DEFAULT
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [lipa_pkg::FIELD_ID_W-1:0]      rsp_id_out,
   input logic [lipa_pkg::STATUS_W-1:0]        rsp_status,
   input logic [lipa_pkg::FREE_COUNT_W-1:0]    rsp_free_count
);

   localparam int FC_W = lipa_pkg::FREE_COUNT_W;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no result comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an empty pool hands out nothing and holds nothing
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lipa_pkg::STATUS_EMPTY
      |-> rsp_id_out == '0 && rsp_free_count == '0)
      else $error("empty status with identifier or nonzero count");

   // a dropped push means the pool is at capacity
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lipa_pkg::STATUS_FULL
      |-> rsp_free_count == FC_W'(DEPTH) && rsp_id_out == '0)
      else $error("full status with count below capacity");

   // count never exceeds capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_free_count) <= DEPTH)
      else $error("free count above capacity");

endmodule

bind lifo_id_pool_allocator lipa_checker #(
   .DEPTH (DEPTH)
) u_lipa_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_id_out     (rsp_chan.id_out),
   .rsp_status     (rsp_chan.status),
   .rsp_free_count (rsp_chan.free_count)
);

>>> bench/lipa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipa_scoreboard
// Watches the request, result and register ports of the identifier pool,
// keeps its own copy of the free-list stack and the id range registers,
// predicts one result per accepted request and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lipa_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   lipa_req_if                             req_mon,
   lipa_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [lipa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lipa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              fail_count,
   output int                              pending_count
);

   localparam int POOL_DEPTH = lipa_pkg::DEPTH_DEFAULT;
   localparam int ID_W       = lipa_pkg::FIELD_ID_W;
   localparam int FC_W       = lipa_pkg::FREE_COUNT_W;

   typedef struct packed {
      logic [ID_W-1:0]      id_out;
      lipa_pkg::status_type status;
      logic [FC_W-1:0]      free_count;
   } pool_result_s;

   logic [ID_W-1:0] pool_ids [POOL_DEPTH];
   int unsigned     pool_level;
   logic [ID_W-1:0] range_lo;
   logic [ID_W-1:0] range_hi;
   pool_result_s    pending_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      pool_level    = 0;
      range_lo      = '0;
      range_hi      = '0;
   end

   // updates the shadow pool and returns what the block should report
   function automatic pool_result_s apply_pool_op(logic [lipa_pkg::FUNC_W-1:0] op,
                                                  logic [ID_W-1:0] value);
      pool_result_s res;
      int           span;
      int           keep;
      res.id_out = '0;
      res.status = lipa_pkg::STATUS_OK;
      case (op)
         lipa_pkg::FUNC_ALLOC: begin
            if (pool_level == 0) begin
               res.status = lipa_pkg::STATUS_EMPTY;
            end else begin
               pool_level--;
               res.id_out = pool_ids[pool_level];
            end
         end
         lipa_pkg::FUNC_FREE: begin
            if (pool_level >= POOL_DEPTH) begin
               res.status = lipa_pkg::STATUS_FULL;
            end else begin
               pool_ids[pool_level] = value;
               pool_level++;
            end
         end
         lipa_pkg::FUNC_INIT: begin
            pool_level = 0;
            if (range_hi >= range_lo) begin
               span = int'(range_hi) - int'(range_lo) + 1;
               keep = span;
               if (span > POOL_DEPTH) begin
                  keep       = POOL_DEPTH;
                  res.status = lipa_pkg::STATUS_TRUNC;
               end
               for (int k = 0; k < keep; k++) pool_ids[k] = range_lo + ID_W'(k);
               pool_level = keep;
            end
         end
         default: ; // unused code leaves the pool alone
      endcase
      res.free_count = FC_W'(pool_level);
      return res;
   endfunction

   function automatic void compare_field(string field, logic [ID_W-1:0] want,
                                         logic [ID_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      pool_result_s want;
      if (reset) begin
         pool_level = 0;
         range_lo   = '0;
         range_hi   = '0;
         pending_results.delete();
      end else begin
         // results first: a result never belongs to a request taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result transfer: id_out %0d status %0d free_count %0d",
                      rsp_mon.id_out, rsp_mon.status, rsp_mon.free_count);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               compare_field("id_out", want.id_out, rsp_mon.id_out);
               compare_field("status", ID_W'(want.status), ID_W'(rsp_mon.status));
               compare_field("free_count", ID_W'(want.free_count),
                             ID_W'(rsp_mon.free_count));
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(apply_pool_op(req_mon.func, req_mon.id_value));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (lipa_pkg::reg_sel_type'(csr_paddr[2]))
               lipa_pkg::REG_ID_MIN: range_lo = csr_pwdata[ID_W-1:0];
               lipa_pkg::REG_ID_MAX: range_hi = csr_pwdata[ID_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count = pending_results.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the identifier pool with directed corner cases (empty pool, full
// pool, empty, exact and truncated init ranges, the unused code) and then
// random phases under a range of id settings, with random gaps on both
// channels and one long result stall; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb;

   localparam int FUNC_W     = lipa_pkg::FUNC_W;
   localparam int FIELD_ID_W = lipa_pkg::FIELD_ID_W;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int LONG_HOLD        = 250;
   localparam int SETTLE_CYCLES    = 4;
   localparam int RANDOM_PHASES    = 11;
   localparam int ITEMS_PER_PHASE  = 36;
   localparam int PRESSURE_ITEMS   = 40;

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [lipa_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lipa_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [lipa_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;
   int                              fail_count;
   int                              pending_count;
   bit                              steady;
   bit                              long_hold_req;
   int                              stall_left;

   lipa_req_if req_chan ();
   lipa_rsp_if rsp_chan ();

   lifo_id_pool_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lipa_scoreboard u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side stalls
   initial begin
      rsp_chan.ready = 1'b0;
      stall_left     = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic [FUNC_W-1:0] op,
                            input logic [FIELD_ID_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.func     <= op;
      req_chan.id_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_random_item(input int alloc_pct, input int free_pct);
      int                r;
      logic [FUNC_W-1:0] op;
      r = $urandom_range(0, 99);
      if (r < alloc_pct) op = lipa_pkg::FUNC_ALLOC;
      else if (r < alloc_pct + free_pct) op = lipa_pkg::FUNC_FREE;
      else if (r < 97) op = lipa_pkg::FUNC_INIT;
      else op = FUNC_UNUSED;
      send_item(op, FIELD_ID_W'($urandom));
   endtask

   // sender pauses until every predicted result has come back
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input lipa_pkg::reg_sel_type sel,
                            input logic [FIELD_ID_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      // upper bits are junk, the block keeps only the id width
      csr_pwdata  <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_range(input int lo, input int hi);
      write_reg(lipa_pkg::REG_ID_MIN, FIELD_ID_W'(lo));
      write_reg(lipa_pkg::REG_ID_MAX, FIELD_ID_W'(hi));
   endtask

   task automatic set_random_range();
      int r;
      int lo;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         // inverted range empties the pool
         lo = $urandom_range(1, 65535);
         set_range(lo, $urandom_range(0, lo - 1));
      end else if (r < 22) begin
         lo = $urandom_range(0, 65000);
         set_range(lo, $urandom_range(lo + 256, 65535));
      end else if (r < 28) begin
         lo = $urandom_range(0, 65280);
         set_range(lo, lo + 255);
      end else begin
         lo = $urandom_range(0, 65535 - 64);
         set_range(lo, lo + $urandom_range(0, 47));
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.func     = lipa_pkg::FUNC_ALLOC;
      req_chan.id_value = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      steady            = 1'b0;
      long_hold_req     = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pool after reset, unused code, plain push and pop
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);
      send_item(FUNC_UNUSED, 16'hFFFF);
      send_item(lipa_pkg::FUNC_FREE, 16'hFFFF);
      send_item(lipa_pkg::FUNC_FREE, 16'h0000);
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);
      send_item(lipa_pkg::FUNC_INIT, 16'h0000);
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);

      // widest range truncates to a full pool
      wait_idle();
      set_range(0, 65535);
      send_item(lipa_pkg::FUNC_INIT, 16'h0000);
      send_item(lipa_pkg::FUNC_FREE, 16'h5A5A);
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);
      send_item(lipa_pkg::FUNC_FREE, 16'hA5A5);
      send_item(lipa_pkg::FUNC_FREE, 16'h1234);
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);
      send_item(FUNC_UNUSED, 16'h0000);

      wait_idle();
      set_range(65535, 0);
      send_item(lipa_pkg::FUNC_INIT, 16'h0000);
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);

      wait_idle();
      set_range(65535, 65535);
      send_item(lipa_pkg::FUNC_INIT, 16'h0000);
      send_item(lipa_pkg::FUNC_ALLOC, 16'h0000);

      // exactly the pool depth, then one more
      wait_idle();
      set_range(100, 355);
      send_item(lipa_pkg::FUNC_INIT, 16'h0000);
      wait_idle();
      write_reg(lipa_pkg::REG_ID_MAX, 16'd356);
      send_item(lipa_pkg::FUNC_INIT, 16'h0000);

      // long result stall while requests keep coming
      wait_idle();
      set_range(7, 30);
      send_item(lipa_pkg::FUNC_INIT, 16'h0000);
      long_hold_req = 1'b1;
      steady        = 1'b1;
      repeat (PRESSURE_ITEMS) send_random_item(30, 60);
      steady = 1'b0;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         steady = (p % 4 == 3);
         set_random_range();
         send_item(lipa_pkg::FUNC_INIT, FIELD_ID_W'($urandom));
         if (p % 2 == 1)
            repeat (ITEMS_PER_PHASE) send_random_item(60, 30);
         else
            repeat (ITEMS_PER_PHASE) send_random_item(25, 65);
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
